FILE: rtl/core/keyboard_serial_tty_input_queue_top_defines.svh
// Assertion macros shared by the queue's checker.
`ifndef KEYBOARD_SERIAL_TTY_INPUT_QUEUE_TOP_DEFINES_SVH
`define KEYBOARD_SERIAL_TTY_INPUT_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, quiet while reset is low.
`define KSTQ_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet while reset is low.
`define KSTQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/kstq_pkg.sv
// Shared types, codes and the scancode translation table for the TTY input queue.
`default_nettype none

package kstq_pkg;

    localparam int KSTQ_SC_DEPTH   = 256;
    localparam int KSTQ_CHAR_DEPTH = 256;

    // Input actions
    localparam logic [1:0] ACT_KEY       = 2'd0;
    localparam logic [1:0] ACT_SERIAL    = 2'd1;
    localparam logic [1:0] ACT_READ_SC   = 2'd2;
    localparam logic [1:0] ACT_READ_CHAR = 2'd3;

    // Signal codes
    localparam logic [1:0] SIG_NONE = 2'd0;
    localparam logic [1:0] SIG_INT  = 2'd1;
    localparam logic [1:0] SIG_QUIT = 2'd2;
    localparam logic [1:0] SIG_STOP = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] REG_SIGNALS_ENABLED  = 3'd0;
    localparam logic [2:0] REG_INTERRUPT_CHAR   = 3'd1;
    localparam logic [2:0] REG_QUIT_CHAR        = 3'd2;
    localparam logic [2:0] REG_SUSPEND_CHAR     = 3'd3;
    localparam logic [2:0] REG_FOREGROUND_GROUP = 3'd4;

    localparam logic       RST_SIGNALS_ENABLED  = 1'b1;
    localparam logic [7:0] RST_INTERRUPT_CHAR   = 8'd3;
    localparam logic [7:0] RST_QUIT_CHAR        = 8'd28;
    localparam logic [7:0] RST_SUSPEND_CHAR     = 8'd26;
    localparam logic [15:0] RST_FOREGROUND_GROUP = 16'd0;

    typedef struct packed {
        logic push;
        logic pop;
    } ring_ctrl_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic pending_next;
    } ring_stat_t;

    // Set-1 press code to unshifted ASCII; zero means no character.
    function automatic logic [7:0] translate(input logic [6:0] code);
        logic [7:0] c;
        case (code)
            7'd1:    c = 8'd27;
            7'd2:    c = 8'h31;
            7'd3:    c = 8'h32;
            7'd4:    c = 8'h33;
            7'd5:    c = 8'h34;
            7'd6:    c = 8'h35;
            7'd7:    c = 8'h36;
            7'd8:    c = 8'h37;
            7'd9:    c = 8'h38;
            7'd10:   c = 8'h39;
            7'd11:   c = 8'h30;
            7'd12:   c = 8'h2D;
            7'd13:   c = 8'h3D;
            7'd14:   c = 8'd8;
            7'd15:   c = 8'd9;
            7'd16:   c = 8'h71;
            7'd17:   c = 8'h77;
            7'd18:   c = 8'h65;
            7'd19:   c = 8'h72;
            7'd20:   c = 8'h74;
            7'd21:   c = 8'h79;
            7'd22:   c = 8'h75;
            7'd23:   c = 8'h69;
            7'd24:   c = 8'h6F;
            7'd25:   c = 8'h70;
            7'd26:   c = 8'h5B;
            7'd27:   c = 8'h5D;
            7'd28:   c = 8'd10;
            7'd30:   c = 8'h61;
            7'd31:   c = 8'h73;
            7'd32:   c = 8'h64;
            7'd33:   c = 8'h66;
            7'd34:   c = 8'h67;
            7'd35:   c = 8'h68;
            7'd36:   c = 8'h6A;
            7'd37:   c = 8'h6B;
            7'd38:   c = 8'h6C;
            7'd39:   c = 8'h3B;
            7'd40:   c = 8'h27;
            7'd41:   c = 8'h60;
            7'd43:   c = 8'h5C;
            7'd44:   c = 8'h7A;
            7'd45:   c = 8'h78;
            7'd46:   c = 8'h63;
            7'd47:   c = 8'h76;
            7'd48:   c = 8'h62;
            7'd49:   c = 8'h6E;
            7'd50:   c = 8'h6D;
            7'd51:   c = 8'h2C;
            7'd52:   c = 8'h2E;
            7'd53:   c = 8'h2F;
            7'd55:   c = 8'h2A;
            7'd57:   c = 8'h20;
            default: c = 8'd0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/kstq_ring.sv
// Ring buffer with one write and one registered read port, one slot kept free.
`default_nettype none

module kstq_ring #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire kstq_pkg::ring_ctrl_t ctrl,
    input  wire logic [WIDTH-1:0]    push_data,
    output logic [WIDTH-1:0]         pop_data,
    output kstq_pkg::ring_stat_t     stat
);
    import kstq_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0] head_reg, head_next, head_inc;
    logic [PW-1:0] tail_reg, tail_next, tail_inc;
    logic [WIDTH-1:0] pop_data_reg;

    always_comb begin
        head_inc  = (head_reg == LAST) ? '0 : head_reg + 1'b1;
        tail_inc  = (tail_reg == LAST) ? '0 : tail_reg + 1'b1;
        head_next = ctrl.push ? head_inc : head_reg;
        tail_next = ctrl.pop ? tail_inc : tail_reg;
        stat.full         = (head_inc == tail_reg);
        stat.empty        = (head_reg == tail_reg);
        stat.pending_next = (head_next != tail_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            mem[head_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.pop) begin
            pop_data_reg <= mem[tail_reg];
        end
    end

    assign pop_data = pop_data_reg;

endmodule

`default_nettype wire

FILE: rtl/core/keyboard_serial_tty_input_queue_top.sv
// Keyboard/serial TTY input queue: top level with scancode and character rings.
//
// Input beats (s_valid/s_ready) carry an action and a data byte: a set-1
// scancode, a serial byte, or a pop request for the scancode or character
// ring. Each beat yields exactly one result beat on m_valid/m_ready with the
// read data, signal report, key event, drop flag, wake flag and the pending
// flags of both rings after that beat.
// Each beat passes the stage register, which holds the decoded beat and the
// ring read data, and then the output register.
// Throughput is one beat per cycle while the receiver does not stall; the ring
// memory read port, registered, sets the first stage.
// When the receiver stalls, the output register holds, the stage behind it
// fills, and s_ready drops until m_ready returns.
// Configuration writes (cfg_wr_en, cfg_index, cfg_wdata) take effect at once;
// the user must make them only while the queue is idle, the block does not enforce it.
// Reset empties both rings, clears both stages and loads the register
// defaults; ring contents are not cleared and no clearing pass is run.
`default_nettype none

module keyboard_serial_tty_input_queue_top #(
    parameter int SCANCODE_RING_DEPTH = kstq_pkg::KSTQ_SC_DEPTH,
    parameter int CHAR_RING_DEPTH     = kstq_pkg::KSTQ_CHAR_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_action,
    input  wire logic [7:0]  s_data_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_read_valid,
    output logic [7:0]       m_read_data,
    output logic [1:0]       m_signal_code,
    output logic [15:0]      m_signal_group,
    output logic             m_key_event_valid,
    output logic [7:0]       m_key_event_char,
    output logic             m_dropped,
    output logic             m_wake_readers,
    output logic             m_scancode_pending,
    output logic             m_char_pending
);
    import kstq_pkg::*;

    typedef struct packed {
        logic        read_valid;
        logic        read_from_sc;
        logic [1:0]  signal_code;
        logic [15:0] signal_group;
        logic        key_event_valid;
        logic [7:0]  key_event_char;
        logic        dropped;
        logic        wake_readers;
        logic        scancode_pending;
        logic        char_pending;
    } stage_t;

    typedef struct packed {
        logic        read_valid;
        logic [7:0]  read_data;
        logic [1:0]  signal_code;
        logic [15:0] signal_group;
        logic        key_event_valid;
        logic [7:0]  key_event_char;
        logic        dropped;
        logic        wake_readers;
        logic        scancode_pending;
        logic        char_pending;
    } result_t;

    logic        sig_en_reg;
    logic [7:0]  int_char_reg, quit_char_reg, susp_char_reg;
    logic [15:0] fg_group_reg;

    logic   stg_valid_reg, stg_valid_next;
    stage_t stg_reg, stg_next;
    logic   out_valid_reg, out_valid_next;
    result_t out_reg, out_next;

    logic out_free, accept;
    logic is_press, is_serial, char_req;
    logic [7:0] key_char, sig_char;
    logic [1:0] sig_raw, sig_eff;

    ring_ctrl_t sc_ctrl, ch_ctrl;
    ring_stat_t sc_stat, ch_stat;
    logic [6:0] sc_rd_data;
    logic [7:0] ch_rd_data;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sig_en_reg    <= RST_SIGNALS_ENABLED;
            int_char_reg  <= RST_INTERRUPT_CHAR;
            quit_char_reg <= RST_QUIT_CHAR;
            susp_char_reg <= RST_SUSPEND_CHAR;
            fg_group_reg  <= RST_FOREGROUND_GROUP;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SIGNALS_ENABLED:  sig_en_reg    <= cfg_wdata[0];
                REG_INTERRUPT_CHAR:   int_char_reg  <= cfg_wdata[7:0];
                REG_QUIT_CHAR:        quit_char_reg <= cfg_wdata[7:0];
                REG_SUSPEND_CHAR:     susp_char_reg <= cfg_wdata[7:0];
                REG_FOREGROUND_GROUP: fg_group_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = !stg_valid_reg || out_free;
    assign accept   = s_valid && s_ready;

    // Decode one beat
    always_comb begin
        is_press  = (s_action == ACT_KEY) && !s_data_byte[7];
        is_serial = (s_action == ACT_SERIAL);
        key_char  = translate(s_data_byte[6:0]);
        sig_char  = is_serial ? s_data_byte : key_char;

        if (!sig_en_reg) begin
            sig_raw = SIG_NONE;
        end else if (sig_char == int_char_reg) begin
            sig_raw = SIG_INT;
        end else if (sig_char == quit_char_reg) begin
            sig_raw = SIG_QUIT;
        end else if (sig_char == susp_char_reg) begin
            sig_raw = SIG_STOP;
        end else begin
            sig_raw = SIG_NONE;
        end

        // a key with no character takes no part in the signal check
        if (is_serial || (is_press && key_char != 8'd0)) begin
            sig_eff = sig_raw;
        end else begin
            sig_eff = SIG_NONE;
        end
        char_req = (is_serial || (is_press && key_char != 8'd0)) && (sig_eff == SIG_NONE);

        sc_ctrl.push = accept && is_press && !sc_stat.full;
        sc_ctrl.pop  = accept && (s_action == ACT_READ_SC) && !sc_stat.empty;
        ch_ctrl.push = accept && char_req && !ch_stat.full;
        ch_ctrl.pop  = accept && (s_action == ACT_READ_CHAR) && !ch_stat.empty;

        stg_next.read_valid   = sc_ctrl.pop || ch_ctrl.pop;
        stg_next.read_from_sc = (s_action == ACT_READ_SC);
        // zero group swallows the signal
        stg_next.signal_code  = (fg_group_reg == 16'd0) ? SIG_NONE : sig_eff;
        stg_next.signal_group = (stg_next.signal_code == SIG_NONE) ? 16'd0 : fg_group_reg;
        stg_next.key_event_valid = is_press && char_req;
        stg_next.key_event_char  = (is_press && char_req) ? key_char : 8'd0;
        stg_next.dropped = (is_press && sc_stat.full) || (char_req && ch_stat.full);
        stg_next.wake_readers     = is_press || is_serial;
        stg_next.scancode_pending = sc_stat.pending_next;
        stg_next.char_pending     = ch_stat.pending_next;
    end

    kstq_ring #(
        .DEPTH (SCANCODE_RING_DEPTH),
        .WIDTH (7)
    ) u_sc_ring (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (sc_ctrl),
        .push_data (s_data_byte[6:0]),
        .pop_data  (sc_rd_data),
        .stat      (sc_stat)
    );

    kstq_ring #(
        .DEPTH (CHAR_RING_DEPTH),
        .WIDTH (8)
    ) u_ch_ring (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ch_ctrl),
        .push_data (sig_char),
        .pop_data  (ch_rd_data),
        .stat      (ch_stat)
    );

    always_comb begin
        stg_valid_next = accept ? 1'b1 : (out_free ? 1'b0 : stg_valid_reg);
        out_valid_next = out_free ? stg_valid_reg : out_valid_reg;

        out_next.read_valid = stg_reg.read_valid;
        if (!stg_reg.read_valid) begin
            out_next.read_data = 8'd0;
        end else if (stg_reg.read_from_sc) begin
            out_next.read_data = translate(sc_rd_data);
        end else begin
            out_next.read_data = ch_rd_data;
        end
        out_next.signal_code      = stg_reg.signal_code;
        out_next.signal_group     = stg_reg.signal_group;
        out_next.key_event_valid  = stg_reg.key_event_valid;
        out_next.key_event_char   = stg_reg.key_event_char;
        out_next.dropped          = stg_reg.dropped;
        out_next.wake_readers     = stg_reg.wake_readers;
        out_next.scancode_pending = stg_reg.scancode_pending;
        out_next.char_pending     = stg_reg.char_pending;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            stg_valid_reg <= stg_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: load stage on accept, output when it frees up
    always_ff @(posedge aclk) begin
        if (accept) begin
            stg_reg <= stg_next;
        end
        if (out_free && stg_valid_reg) begin
            out_reg <= out_next;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_read_valid       = out_reg.read_valid;
    assign m_read_data        = out_reg.read_data;
    assign m_signal_code      = out_reg.signal_code;
    assign m_signal_group     = out_reg.signal_group;
    assign m_key_event_valid  = out_reg.key_event_valid;
    assign m_key_event_char   = out_reg.key_event_char;
    assign m_dropped          = out_reg.dropped;
    assign m_wake_readers     = out_reg.wake_readers;
    assign m_scancode_pending = out_reg.scancode_pending;
    assign m_char_pending     = out_reg.char_pending;

endmodule

`default_nettype wire

FILE: rtl/core/kstq_checker.sv
// Port-level checker for the TTY input queue, bound to the top level.
`default_nettype none
`include "keyboard_serial_tty_input_queue_top_defines.svh"

module kstq_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        cfg_wr_en,
    input wire logic [2:0]  cfg_index,
    input wire logic [15:0] cfg_wdata,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic [1:0]  s_action,
    input wire logic [7:0]  s_data_byte,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_read_valid,
    input wire logic [7:0]  m_read_data,
    input wire logic [1:0]  m_signal_code,
    input wire logic [15:0] m_signal_group,
    input wire logic        m_key_event_valid,
    input wire logic [7:0]  m_key_event_char,
    input wire logic        m_dropped,
    input wire logic        m_wake_readers,
    input wire logic        m_scancode_pending,
    input wire logic        m_char_pending
);
    import kstq_pkg::*;

    // a stalled result beat holds
    `KSTQ_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_read_data) && $stable(m_signal_code) && $stable(m_key_event_char) && $stable(m_dropped), "result beat changed while stalled")

    // a read reports nothing but its data and the pending flags
    `KSTQ_ASSERT_NOW(a_read_alone, aclk, aresetn, m_valid && m_read_valid, !m_wake_readers && !m_key_event_valid && (m_signal_code == SIG_NONE) && !m_dropped, "read beat carries arrival fields")

    // group travels with the signal and never without it
    `KSTQ_ASSERT_NOW(a_sig_group, aclk, aresetn, m_valid, (m_signal_code == SIG_NONE) == (m_signal_group == 16'd0), "signal code and group disagree")

    // a key event is a consumed-free, nonzero press character
    `KSTQ_ASSERT_NOW(a_key_event, aclk, aresetn, m_valid && m_key_event_valid, m_wake_readers && (m_signal_code == SIG_NONE) && (m_key_event_char != 8'd0), "malformed key event")

endmodule

bind keyboard_serial_tty_input_queue_top kstq_checker u_kstq_checker (.*);

`default_nettype wire
